@@ rtl/core/fvs_pkg.sv @@
// Package for the frame victim selector: sizes, mode codes and the
// controller/datapath command and status structs. No dependencies.
package fvs_pkg;
	localparam int NumFrames = 64;
	localparam int NumProcs = 16;
	localparam int StampBits = 32;
	localparam int FrameW = 6;
	localparam int ProcW = 4;
	localparam int PageW = 12;

	localparam logic [1:0] MODE_ACCESS = 2'd0;
	localparam logic [1:0] MODE_LOAD = 2'd1;
	localparam logic [1:0] MODE_SELECT = 2'd2;

	localparam logic CFG_ALG = 1'b0;
	localparam logic CFG_POL = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;     // latch the input beat
		logic do_access;   // apply access to the latched frame
		logic do_load;     // apply load to the latched frame
		logic scan_start;  // reset scan position for a new pass
		logic scan_step;   // visit the frame at the scan position
		logic evict;       // free the chosen victim and fill the result
		logic clear_res;   // fill an all-zero result
	} fvs_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [1:0] mode;
		logic       lru;
		logic       last;      // evaluated frame ends the scan: final frame of a pass, or a clock hit
		logic       found;     // victim picked
		logic       any;       // a candidate was seen in this select
	} fvs_sts_t;
endpackage

@@ rtl/core/frame_victim_selector_core.sv @@
// Frame victim selector top level: controller plus datapath. Depends on fvs_pkg.
// Access and load are applied directly; a select scans the frame table in passes,
// one frame per cycle plus a read stage: LRU makes one pass, clock up to four.
// One item in flight at a time; the result register holds while stalled.
// Reset clears occupancy, use and dirty bits, hands, stamp counter and config.
module frame_victim_selector_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  mode,
	input  logic [5:0]  frame_index,
	input  logic [3:0]  process_id,
	input  logic [11:0] page_number,
	input  logic        is_write,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        victim_found,
	output logic [5:0]  victim_frame,
	output logic [3:0]  victim_process,
	output logic [11:0] victim_page,
	output logic        victim_dirty,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic        cfg_data
);
	import fvs_pkg::*;

	fvs_cmd_t cmd;
	fvs_sts_t sts;

	assign cfg_ready = 1'b1;

	fvs_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall, .sts, .cmd
	);

	fvs_datapath u_dp (
		.clk, .arst_n, .cmd, .sts, .cfg_valid, .cfg_index, .cfg_data,
		.mode, .frame_index, .process_id, .page_number, .is_write,
		.victim_found, .victim_frame, .victim_process, .victim_page, .victim_dirty
	);
endmodule

@@ rtl/core/fvs_datapath.sv @@
// Datapath: frame table flops, stamp counter, hands, a pipelined one-frame-per-cycle scan
// unit with registered table reads, and the result register. Depends on fvs_pkg.
module fvs_datapath (
	input  logic                    clk,
	input  logic                    arst_n,
	input  fvs_pkg::fvs_cmd_t       cmd,
	output fvs_pkg::fvs_sts_t       sts,
	input  logic                    cfg_valid,
	input  logic                    cfg_index,
	input  logic                    cfg_data,
	input  logic [1:0]              mode,
	input  logic [5:0]              frame_index,
	input  logic [3:0]              process_id,
	input  logic [11:0]             page_number,
	input  logic                    is_write,
	output logic                    victim_found,
	output logic [5:0]              victim_frame,
	output logic [3:0]              victim_process,
	output logic [11:0]             victim_page,
	output logic                    victim_dirty
);
	import fvs_pkg::*;

	logic                  alg_q, pol_q;
	logic [1:0]            mode_q;
	logic [FrameW-1:0]     fi_q;
	logic [ProcW-1:0]      pid_q;
	logic [PageW-1:0]      page_q;
	logic                  wr_q;
	logic [NumFrames-1:0]  occ_q, use_q, dirty_q;
	logic [ProcW-1:0]      owner_q [NumFrames];
	logic [PageW-1:0]      pagemem_q [NumFrames];
	logic [StampBits-1:0]  stamp_q [NumFrames];
	logic [FrameW-1:0]     phand_q [NumProcs];
	logic [FrameW-1:0]     ghand_q;
	logic [StampBits-1:0]  ctr_q;
	logic [FrameW-1:0]     pos_q, cnt_q, vic_q;
	logic [1:0]            pass_q;
	logic                  found_q, any_q;
	logic [StampBits-1:0]  best_q;
	logic                  issue_done_q;
	logic [ProcW-1:0]      vic_owner_q;
	logic [PageW-1:0]      vic_page_q;

	// Frame read from the table into registers, evaluated in this stage.
	logic [FrameW-1:0]     pos_s1;
	logic                  val_s1, last_s1;
	logic [ProcW-1:0]      owner_s1;
	logic [PageW-1:0]      page_s1;
	logic [StampBits-1:0]  stamp_s1;

	logic                  fixed, cand, hit, eval;
	logic [FrameW-1:0]     start;

	// Candidate test on the frame in the evaluation stage.
	assign fixed = ~pol_q;
	assign eval  = cmd.scan_step && val_s1;
	assign cand  = occ_q[pos_s1] && (!fixed || owner_s1 == pid_q);
	assign start = alg_q ? (fixed ? phand_q[pid_q] : ghand_q) : '0;
	assign hit   = alg_q ? (!use_q[pos_s1] && (dirty_q[pos_s1] == pass_q[0]))
	                     : (!any_q || stamp_s1 < best_q);

	assign sts.mode  = mode_q;
	assign sts.lru   = ~alg_q;
	assign sts.last  = eval && (last_s1 || (alg_q && cand && hit));
	assign sts.found = found_q;
	assign sts.any   = any_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alg_q <= 1'b0;
			pol_q <= 1'b0;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_ALG) alg_q <= cfg_data;
			else pol_q <= cfg_data;
		end
	end

	// Input capture, payload tables and their registered scan reads.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q <= mode;
			fi_q   <= frame_index;
			pid_q  <= process_id;
			page_q <= page_number;
			wr_q   <= is_write;
		end
		if (cmd.do_load) begin
			owner_q[fi_q]   <= pid_q;
			pagemem_q[fi_q] <= page_q;
		end
		if ((cmd.do_load) || (cmd.do_access && occ_q[fi_q]))
			stamp_q[fi_q] <= ctr_q;
		if (cmd.scan_step && !issue_done_q) begin
			owner_s1 <= owner_q[pos_q];
			page_s1  <= pagemem_q[pos_q];
			stamp_s1 <= stamp_q[pos_q];
		end
		// Owner and page of the current best victim.
		if (eval && cand && hit) begin
			vic_owner_q <= owner_s1;
			vic_page_q  <= page_s1;
		end
	end

	// Control state of the frame table, hands and scan unit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q   <= '0;
			use_q   <= '0;
			dirty_q <= '0;
			for (int i = 0; i < NumProcs; i++) phand_q[i] <= '0;
			ghand_q <= '0;
			ctr_q   <= '0;
			pos_q   <= '0;
			cnt_q   <= '0;
			vic_q   <= '0;
			pass_q  <= '0;
			found_q <= 1'b0;
			any_q   <= 1'b0;
			best_q  <= '0;
			issue_done_q <= 1'b0;
			pos_s1  <= '0;
			val_s1  <= 1'b0;
			last_s1 <= 1'b0;
			victim_found   <= 1'b0;
			victim_frame   <= '0;
			victim_process <= '0;
			victim_page    <= '0;
			victim_dirty   <= 1'b0;
		end else begin
			if (cmd.do_access && occ_q[fi_q]) begin
				use_q[fi_q] <= 1'b1;
				if (wr_q) dirty_q[fi_q] <= 1'b1;
			end
			if (cmd.do_load) begin
				occ_q[fi_q]   <= 1'b1;
				use_q[fi_q]   <= 1'b1;
				dirty_q[fi_q] <= 1'b0;
			end
			if ((cmd.do_load || (cmd.do_access && occ_q[fi_q])) && ctr_q != '1)
				ctr_q <= ctr_q + 1'b1;
			if (cmd.capture) begin
				pass_q  <= '0;
				found_q <= 1'b0;
				any_q   <= 1'b0;
			end
			if (cmd.scan_start) begin
				pos_q        <= start;
				cnt_q        <= '0;
				issue_done_q <= 1'b0;
				val_s1       <= 1'b0;
			end
			// One table read issued and one frame evaluated per cycle.
			if (cmd.scan_step) begin
				val_s1 <= !issue_done_q;
				if (!issue_done_q) begin
					pos_q   <= pos_q + 1'b1;
					cnt_q   <= cnt_q + 1'b1;
					pos_s1  <= pos_q;
					last_s1 <= (cnt_q == FrameW'(NumFrames - 1));
					if (cnt_q == FrameW'(NumFrames - 1)) issue_done_q <= 1'b1;
				end
				if (val_s1) begin
					if (last_s1) pass_q <= pass_q + 1'b1;
					if (cand) begin
						any_q <= 1'b1;
						if (hit) begin
							vic_q   <= pos_s1;
							best_q  <= stamp_s1;
							found_q <= 1'b1;
						end else if (alg_q && pass_q[0]) begin
							use_q[pos_s1] <= 1'b0;
						end
					end
				end
			end
			// Result and victim release.
			if (cmd.clear_res) begin
				victim_found   <= 1'b0;
				victim_frame   <= '0;
				victim_process <= '0;
				victim_page    <= '0;
				victim_dirty   <= 1'b0;
			end
			if (cmd.evict) begin
				victim_found   <= 1'b1;
				victim_frame   <= vic_q;
				victim_process <= vic_owner_q;
				victim_page    <= vic_page_q;
				victim_dirty   <= dirty_q[vic_q];
				occ_q[vic_q]   <= 1'b0;
				use_q[vic_q]   <= 1'b0;
				dirty_q[vic_q] <= 1'b0;
				if (alg_q) begin
					if (fixed) phand_q[pid_q] <= vic_q + 1'b1;
					else ghand_q <= vic_q + 1'b1;
				end
			end
		end
	end
endmodule

@@ rtl/core/fvs_ctrl.sv @@
// Controller state machine: sequences access, load and victim scans.
// Depends on fvs_pkg.
module fvs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  fvs_pkg::fvs_sts_t sts,
	output fvs_pkg::fvs_cmd_t cmd
);
	import fvs_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_EXEC = 3'd1;
	localparam logic [2:0] ST_PREP = 3'd2;
	localparam logic [2:0] ST_SCAN = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;
	localparam logic [2:0] ST_OUT  = 3'd5;

	logic [2:0] state_q, state_d;
	logic       out_free;
	logic [1:0] npass_q;
	logic       pass_ok;

	// The result register is free when empty or being taken this cycle.
	assign out_free = !out_valid || !out_stall;
	assign in_stall = (state_q != ST_IDLE);

	// Pass counter for the clock scan.
	assign pass_ok = (npass_q != 2'd3);

	always_comb begin
		cmd = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (sts.mode == MODE_SELECT) begin
					state_d = ST_PREP;
				end else if (out_free) begin
					cmd.do_access = (sts.mode == MODE_ACCESS);
					cmd.do_load   = (sts.mode == MODE_LOAD);
					cmd.clear_res = 1'b1;
					state_d = ST_OUT;
				end
			end
			ST_PREP: begin
				cmd.scan_start = 1'b1;
				state_d = ST_SCAN;
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.last) state_d = ST_DONE;
			end
			ST_DONE: begin
				// Clock passes repeat until found, at most four, only with candidates.
				if (!sts.found && !sts.lru && sts.any && pass_ok) begin
					state_d = ST_PREP;
				end else if (out_free) begin
					cmd.evict     = sts.found;
					cmd.clear_res = !sts.found;
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_valid <= 1'b0;
			npass_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.capture) npass_q <= '0;
			else if (state_q == ST_DONE && state_d == ST_PREP) npass_q <= npass_q + 1'b1;
			if (cmd.evict || cmd.clear_res) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
		end
	end
endmodule
